@@ rtl/lpsc_pkg.sv @@
`default_nettype none

package lpsc_pkg;

  // Field widths of the channel payloads.
  localparam int unsigned RecordSizeW = 24;
  localparam int unsigned ByteW       = 8;

  // Default width of the record size and position counters.
  localparam int unsigned RecordSizeBitsDef = 24;

  // Sample-mode header bookkeeping.
  localparam int unsigned LenAccW  = 32;
  localparam int unsigned NextHdrW = 33;
  localparam int unsigned HdrIdxW  = 2;

  // Configuration-record parsing.
  localparam int unsigned EntryLenW    = 16;
  localparam int unsigned EntryCntW    = 8;
  localparam logic [7:0]  AvccVersion  = 8'd1;
  localparam logic [7:0]  SpsCountMask = 8'd31;
  localparam int unsigned AvccMinSize  = 5;
  localparam int unsigned AvccHdrLast  = 4;
  localparam int unsigned HdrLookahead = 4;

  // Parser phases for configuration records.
  typedef enum logic [2:0] {
    PhDone     = 3'd0,
    PhVersion  = 3'd1,
    PhSkip     = 3'd2,
    PhSpsCount = 3'd3,
    PhPpsCount = 3'd4,
    PhLenHi    = 3'd5,
    PhLenLo    = 3'd6,
    PhPayload  = 3'd7
  } phase_e;

  // Record mode latched on the first byte of a record.
  typedef enum logic {
    ModeSample = 1'b0,
    ModeConfig = 1'b1
  } mode_e;

endpackage

`default_nettype wire

@@ rtl/lpsc_in_if.sv @@
`default_nettype none

// Input byte channel.
interface lpsc_in_if;
  logic                                valid;
  logic                                ready;
  logic                                func;
  logic [lpsc_pkg::ByteW-1:0]          data_byte;
  logic                                first_of_record;
  logic [lpsc_pkg::RecordSizeW-1:0]    record_size;

  modport source (
    output valid, func, data_byte, first_of_record, record_size,
    input  ready
  );
  modport sink (
    input  valid, func, data_byte, first_of_record, record_size,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/lpsc_out_if.sv @@
`default_nettype none

// Output byte channel.
interface lpsc_out_if;
  logic                       valid;
  logic                       ready;
  logic [lpsc_pkg::ByteW-1:0] out_byte;
  logic                       out_last;

  modport source (
    output valid, out_byte, out_last,
    input  ready
  );
  modport sink (
    input  valid, out_byte, out_last,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/length_prefix_to_start_code.sv @@
// Converts length-prefixed H.264 data to Annex B start-code form, one input
// byte per beat. In sample records every byte yields exactly one output beat
// and the block takes a new byte every cycle unless the output stalls; each
// 4-byte length header comes out as 00 00 00 01. In configuration (avcC)
// records, header, count and length bytes yield nothing, payload bytes yield
// one beat each, and the second length byte of an entry yields a 4-beat start
// code, during which the input is held while the output register drains.
// The output register lets a new byte enter in the cycle its predecessor's
// last beat is taken. There is no clearing pass; the block is ready right
// after reset.

`default_nettype none

module length_prefix_to_start_code #(
  parameter int unsigned RecordSizeBits = lpsc_pkg::RecordSizeBitsDef
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  lpsc_in_if.sink     in_i,
  lpsc_out_if.source  out_o
);

  localparam int unsigned PW = RecordSizeBits + 1;
  localparam int unsigned LW = RecordSizeBits + lpsc_pkg::EntryLenW;
  localparam logic [RecordSizeBits-1:0] PosMax = {RecordSizeBits{1'b1}};

  // Parsing state.
  lpsc_pkg::mode_e                     mode_q, mode_d;
  logic [RecordSizeBits-1:0]           pos_q, pos_d;
  logic [RecordSizeBits-1:0]           size_q, size_d;
  logic [lpsc_pkg::NextHdrW-1:0]       nhp_q, nhp_d;
  logic [lpsc_pkg::HdrIdxW-1:0]        hidx_q, hidx_d;
  logic [lpsc_pkg::LenAccW-1:0]        acc_q, acc_d;
  lpsc_pkg::phase_e                    phase_q, phase_d;
  logic [lpsc_pkg::EntryCntW-1:0]      ent_q, ent_d;
  logic                                pps_q, pps_d;
  logic [lpsc_pkg::EntryLenW-1:0]      ebl_q, ebl_d;

  // Output register: one byte or a start-code burst.
  logic                       busy_q, busy_d;
  logic                       sc_q, sc_d;
  logic [1:0]                 idx_q, idx_d;
  logic [lpsc_pkg::ByteW-1:0] byte_q, byte_d;

  // State as seen by the current byte, after a record start clears it.
  lpsc_pkg::mode_e                mode_e;
  logic [RecordSizeBits-1:0]      pos_e;
  logic [RecordSizeBits-1:0]      size_e;
  logic [lpsc_pkg::NextHdrW-1:0]  nhp_e;
  logic [lpsc_pkg::HdrIdxW-1:0]   hidx_e;
  logic [lpsc_pkg::LenAccW-1:0]   acc_e;
  lpsc_pkg::phase_e               phase_e_s;
  logic [lpsc_pkg::EntryCntW-1:0] ent_e;
  logic                           pps_e;
  logic [lpsc_pkg::EntryLenW-1:0] ebl_e;

  logic [RecordSizeBits-1:0]      rs_m;
  logic [lpsc_pkg::ByteW-1:0]     b;
  logic                           in_fire, out_fire, out_done;
  logic                           emit_one, emit_sc;
  logic [lpsc_pkg::LenAccW-1:0]   acc_shift;
  logic [lpsc_pkg::EntryLenW-1:0] len;
  logic [RecordSizeBits-1:0]      rem;
  logic [lpsc_pkg::EntryCntW-1:0] ent_dec;
  lpsc_pkg::phase_e               fin_phase;
  logic [lpsc_pkg::EntryLenW-1:0] ebl_dec;

  assign b    = in_i.data_byte;
  assign rs_m = RecordSizeBits'(in_i.record_size);

  // Handshake: the input is free when the output holds nothing or drains now.
  assign out_fire   = out_o.valid && out_o.ready;
  assign out_done   = out_fire && out_o.out_last;
  assign in_i.ready = !busy_q || out_done;
  assign in_fire    = in_i.valid && in_i.ready;

  // Output beat selection.
  assign out_o.valid    = busy_q;
  assign out_o.out_last = !sc_q || (idx_q == 2'd3);
  assign out_o.out_byte = sc_q ? ((idx_q == 2'd3) ? 8'd1 : 8'd0) : byte_q;

  // A record start clears the parsing state before the byte is processed.
  always_comb begin
    if (in_i.first_of_record) begin
      mode_e    = lpsc_pkg::mode_e'(in_i.func);
      pos_e     = '0;
      size_e    = rs_m;
      nhp_e     = '0;
      hidx_e    = '0;
      acc_e     = '0;
      phase_e_s = in_i.func ? lpsc_pkg::PhVersion : lpsc_pkg::PhDone;
      ent_e     = '0;
      pps_e     = 1'b0;
      ebl_e     = '0;
    end else begin
      mode_e    = mode_q;
      pos_e     = pos_q;
      size_e    = size_q;
      nhp_e     = nhp_q;
      hidx_e    = hidx_q;
      acc_e     = acc_q;
      phase_e_s = phase_q;
      ent_e     = ent_q;
      pps_e     = pps_q;
      ebl_e     = ebl_q;
    end
  end

  // Shared helpers for header and entry handling.
  assign acc_shift = {acc_e[lpsc_pkg::LenAccW-9:0], b};
  assign len       = {acc_e[7:0], b};
  assign rem       = size_e - pos_e - RecordSizeBits'(1);
  assign ent_dec   = ent_e - lpsc_pkg::EntryCntW'(1);
  assign ebl_dec   = ebl_e - lpsc_pkg::EntryLenW'(1);

  // Phase after an entry of a list is finished.
  always_comb begin
    if (ent_dec != '0) begin
      fin_phase = lpsc_pkg::PhLenHi;
    end else if (!pps_e) begin
      fin_phase = lpsc_pkg::PhPpsCount;
    end else begin
      fin_phase = lpsc_pkg::PhDone;
    end
  end

  // Next parsing state and the results of the current byte.
  always_comb begin
    mode_d   = mode_e;
    size_d   = size_e;
    nhp_d    = nhp_e;
    hidx_d   = hidx_e;
    acc_d    = acc_e;
    phase_d  = phase_e_s;
    ent_d    = ent_e;
    pps_d    = pps_e;
    ebl_d    = ebl_e;
    pos_d    = (pos_e != PosMax) ? pos_e + RecordSizeBits'(1) : pos_e;
    emit_one = 1'b0;
    emit_sc  = 1'b0;
    byte_d   = b;

    if (mode_e == lpsc_pkg::ModeSample) begin
      emit_one = 1'b1;
      if (hidx_e == '0) begin
        if ((lpsc_pkg::NextHdrW'(pos_e) == nhp_e) &&
            (PW'(pos_e) + PW'(lpsc_pkg::HdrLookahead) < PW'(size_e))) begin
          hidx_d = lpsc_pkg::HdrIdxW'(1);
          acc_d  = lpsc_pkg::LenAccW'(b);
          byte_d = 8'd0;
        end
      end else begin
        acc_d = acc_shift;
        if (hidx_e == 2'd3) begin
          byte_d = 8'd1;
          nhp_d  = lpsc_pkg::NextHdrW'(pos_e) + lpsc_pkg::NextHdrW'(1)
                 + lpsc_pkg::NextHdrW'(acc_shift);
          hidx_d = '0;
        end else begin
          hidx_d = hidx_e + lpsc_pkg::HdrIdxW'(1);
          byte_d = 8'd0;
        end
      end
    end else if (pos_e >= size_e) begin
      phase_d = lpsc_pkg::PhDone;
    end else begin
      case (phase_e_s)
        lpsc_pkg::PhVersion: begin
          phase_d = ((PW'(size_e) >= PW'(lpsc_pkg::AvccMinSize)) &&
                     (b == lpsc_pkg::AvccVersion)) ? lpsc_pkg::PhSkip : lpsc_pkg::PhDone;
        end
        lpsc_pkg::PhSkip: begin
          if (PW'(pos_e) >= PW'(lpsc_pkg::AvccHdrLast)) begin
            phase_d = lpsc_pkg::PhSpsCount;
          end
        end
        lpsc_pkg::PhSpsCount: begin
          ent_d   = b & lpsc_pkg::SpsCountMask;
          pps_d   = 1'b0;
          phase_d = ((b & lpsc_pkg::SpsCountMask) != '0) ? lpsc_pkg::PhLenHi
                                                         : lpsc_pkg::PhPpsCount;
        end
        lpsc_pkg::PhPpsCount: begin
          ent_d   = b;
          pps_d   = 1'b1;
          phase_d = (b != '0) ? lpsc_pkg::PhLenHi : lpsc_pkg::PhDone;
        end
        lpsc_pkg::PhLenHi: begin
          acc_d   = lpsc_pkg::LenAccW'(b);
          phase_d = lpsc_pkg::PhLenLo;
        end
        lpsc_pkg::PhLenLo: begin
          acc_d = lpsc_pkg::LenAccW'(len);
          if (LW'(len) > LW'(rem)) begin
            phase_d = lpsc_pkg::PhDone;
          end else begin
            emit_sc = 1'b1;
            ebl_d   = len;
            if (len == '0) begin
              ent_d   = ent_dec;
              phase_d = fin_phase;
            end else begin
              phase_d = lpsc_pkg::PhPayload;
            end
          end
        end
        lpsc_pkg::PhPayload: begin
          emit_one = 1'b1;
          ebl_d    = ebl_dec;
          if (ebl_dec == '0) begin
            ent_d   = ent_dec;
            phase_d = fin_phase;
          end
        end
        default: begin
          phase_d = lpsc_pkg::PhDone;
        end
      endcase
    end
  end

  // Output register control.
  always_comb begin
    busy_d = busy_q;
    sc_d   = sc_q;
    idx_d  = idx_q;
    if (in_fire && (emit_one || emit_sc)) begin
      busy_d = 1'b1;
      sc_d   = emit_sc;
      idx_d  = 2'd0;
    end else if (out_done) begin
      busy_d = 1'b0;
    end else if (out_fire) begin
      idx_d = idx_q + 2'd1;
    end
  end

  // Control state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= lpsc_pkg::ModeSample;
      pos_q   <= '0;
      size_q  <= '0;
      nhp_q   <= '0;
      hidx_q  <= '0;
      acc_q   <= '0;
      phase_q <= lpsc_pkg::PhDone;
      ent_q   <= '0;
      pps_q   <= 1'b0;
      ebl_q   <= '0;
      busy_q  <= 1'b0;
      sc_q    <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      if (in_fire) begin
        mode_q  <= mode_d;
        pos_q   <= pos_d;
        size_q  <= size_d;
        nhp_q   <= nhp_d;
        hidx_q  <= hidx_d;
        acc_q   <= acc_d;
        phase_q <= phase_d;
        ent_q   <= ent_d;
        pps_q   <= pps_d;
        ebl_q   <= ebl_d;
      end
      busy_q <= busy_d;
      sc_q   <= sc_d;
      idx_q  <= idx_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (in_fire && emit_one) begin
      byte_q <= byte_d;
    end
  end

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`default_nettype none

module tb_top;
  import lpsc_pkg::*;

  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned HoldCycles  = 300;
  localparam logic [ByteW-1:0] StartCode [4] = '{8'h00, 8'h00, 8'h00, 8'h01};
  localparam logic [RecordSizeW-1:0] PosMax = '1;

  // One input beat as the sender offers it.
  typedef struct packed {
    logic                   func;
    logic [ByteW-1:0]       data;
    logic                   first;
    logic [RecordSizeW-1:0] size;
  } in_byte_t;

  // One output beat as the converter should produce it.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } out_byte_t;

  // Shapes of generated configuration records, well-formed and broken.
  typedef enum int {
    CfgWellFormed,
    CfgBadVersion,
    CfgShort,
    CfgTruncated,
    CfgOverlong,
    CfgPastEnd,
    CfgHugeSize
  } cfg_shape_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  lpsc_in_if  in_ch ();
  lpsc_out_if out_ch ();

  length_prefix_to_start_code dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #5 clk_i = ~clk_i;

  // Expected output beats, oldest first.
  out_byte_t expected_beats[$];
  // Bytes of the record being built.
  logic [ByteW-1:0] rec_q[$];

  int unsigned errors      = 0;
  int unsigned items_sent  = 0;
  int unsigned cycle_count = 0;
  int          hold_cycles = 0;
  int          gap_pct     = 0;
  bit          idle_on     = 1'b1;

  // Converter state as predicted by the testbench.
  mode_e                  cv_mode;
  logic [RecordSizeW-1:0] cv_pos;
  logic [RecordSizeW-1:0] cv_size;
  logic [NextHdrW-1:0]    cv_next_hdr;
  logic [HdrIdxW-1:0]     cv_hdr_idx;
  logic [LenAccW-1:0]     cv_len;
  phase_e                 cv_phase;
  logic [EntryCntW-1:0]   cv_entries;
  logic                   cv_in_pps;
  logic [EntryLenW-1:0]   cv_entry_left;

  function automatic void clear_parser();
    cv_mode       = ModeSample;
    cv_pos        = '0;
    cv_size       = '0;
    cv_next_hdr   = '0;
    cv_hdr_idx    = '0;
    cv_len        = '0;
    cv_phase      = PhDone;
    cv_entries    = '0;
    cv_in_pps     = 1'b0;
    cv_entry_left = '0;
  endfunction

  // After an entry, move on to the next entry, to the picture sets or stop.
  function automatic void close_entry();
    cv_entries = cv_entries - 1'b1;
    if (cv_entries != 0) begin
      cv_phase = PhLenHi;
    end else if (!cv_in_pps) begin
      cv_phase = PhPpsCount;
    end else begin
      cv_phase = PhDone;
    end
  endfunction

  // Work out the output beats that one accepted input byte causes.
  function automatic void convert_byte(input in_byte_t it);
    logic [ByteW-1:0]       res[$];
    logic [ByteW-1:0]       o;
    logic [RecordSizeW-1:0] p;
    logic [EntryLenW-1:0]   len16;
    out_byte_t              beat;
    if (it.first) begin
      clear_parser();
      cv_mode  = mode_e'(it.func);
      cv_size  = it.size;
      cv_phase = it.func ? PhVersion : PhDone;
    end
    p = cv_pos;

    if (cv_mode == ModeSample) begin
      // Sample bytes: header bytes become the start code, the rest pass.
      o = it.data;
      if (cv_hdr_idx == 0) begin
        if ({9'd0, p} == cv_next_hdr &&
            {1'b0, p} + 25'(HdrLookahead) < {1'b0, cv_size}) begin
          cv_hdr_idx = 1;
          cv_len     = {24'd0, it.data};
          o          = StartCode[0];
        end
      end else begin
        cv_len = {cv_len[23:0], it.data};
        if (cv_hdr_idx == 3) begin
          o           = StartCode[3];
          cv_next_hdr = {9'd0, p} + 33'd1 + {1'b0, cv_len};
          cv_hdr_idx  = 0;
        end else begin
          cv_hdr_idx = cv_hdr_idx + 1'b1;
          o          = StartCode[0];
        end
      end
      res.push_back(o);
    end else if (p >= cv_size) begin
      cv_phase = PhDone;
    end else begin
      // Configuration record parser.
      case (cv_phase)
        PhVersion: begin
          cv_phase = (cv_size >= RecordSizeW'(AvccMinSize) && it.data == AvccVersion) ?
                     PhSkip : PhDone;
        end
        PhSkip: begin
          if (p >= RecordSizeW'(AvccHdrLast)) cv_phase = PhSpsCount;
        end
        PhSpsCount: begin
          cv_entries = it.data & SpsCountMask;
          cv_in_pps  = 1'b0;
          cv_phase   = (cv_entries != 0) ? PhLenHi : PhPpsCount;
        end
        PhPpsCount: begin
          cv_entries = it.data;
          cv_in_pps  = 1'b1;
          cv_phase   = (cv_entries != 0) ? PhLenHi : PhDone;
        end
        PhLenHi: begin
          cv_len   = {24'd0, it.data};
          cv_phase = PhLenLo;
        end
        PhLenLo: begin
          len16  = {cv_len[7:0], it.data};
          cv_len = {16'd0, len16};
          // An entry longer than what is left of the record ends the output.
          if ({8'd0, len16} > cv_size - p - 24'd1) begin
            cv_phase = PhDone;
          end else begin
            for (int k = 0; k < 4; k++) res.push_back(StartCode[k]);
            cv_entry_left = len16;
            if (len16 == 0) begin
              close_entry();
            end else begin
              cv_phase = PhPayload;
            end
          end
        end
        PhPayload: begin
          res.push_back(it.data);
          cv_entry_left = cv_entry_left - 1'b1;
          if (cv_entry_left == 0) close_entry();
        end
        default: cv_phase = PhDone;
      endcase
    end

    if (p != PosMax) cv_pos = p + 1'b1;
    foreach (res[i]) begin
      beat.data = res[i];
      beat.last = (i == res.size() - 1);
      expected_beats.push_back(beat);
    end
  endfunction

  // Offer one byte, possibly after a gap, and wait until it is taken.
  task automatic send_byte(input in_byte_t it);
    int gap;
    if (idle_on && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      gap = $urandom_range(1, 19);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid           <= 1'b1;
    in_ch.func            <= it.func;
    in_ch.data_byte       <= it.data;
    in_ch.first_of_record <= it.first;
    in_ch.record_size     <= it.size;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    convert_byte(it);
    items_sent++;
  endtask

  // Send the bytes of rec_q as one record; func and size only count on the first.
  task automatic send_record(input mode_e m, input logic [RecordSizeW-1:0] decl);
    in_byte_t it;
    gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 12;
    foreach (rec_q[i]) begin
      it.first = (i == 0);
      it.func  = (i == 0) ? m : 1'($urandom_range(0, 1));
      it.data  = rec_q[i];
      it.size  = (i == 0) ? decl : RecordSizeW'($urandom);
      send_byte(it);
    end
  endtask

  // Sample record of n bytes, mostly with consistent length headers.
  task automatic build_sample_record(input int n);
    int          pos;
    int          room;
    logic [31:0] len;
    rec_q.delete();
    pos = 0;
    while (pos < n) begin
      if (pos + 4 < n && $urandom_range(0, 9) != 0) begin
        room = n - pos - 4;
        if (room > 16) room = 16;
        len = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, room);
        rec_q.push_back(len[31:24]);
        rec_q.push_back(len[23:16]);
        rec_q.push_back(len[15:8]);
        rec_q.push_back(len[7:0]);
        pos += 4;
        for (int k = 0; k < 64 && k < len && pos < n; k++) begin
          rec_q.push_back(8'($urandom));
          pos++;
        end
      end else begin
        rec_q.push_back(8'($urandom));
        pos++;
      end
    end
  endtask

  task automatic push_entries(input int count);
    int len;
    repeat (count) begin
      len = $urandom_range(0, 6);
      rec_q.push_back(8'(len >> 8));
      rec_q.push_back(8'(len));
      repeat (len) rec_q.push_back(8'($urandom));
    end
  endtask

  // Configuration record of the given shape; returns the declared size.
  task automatic build_config_record(input cfg_shape_e shape,
                                     output logic [RecordSizeW-1:0] decl);
    logic [ByteW-1:0] version;
    logic [15:0]      len16;
    int               sps;
    int               pps;
    int               body;
    bit               wild;
    rec_q.delete();
    wild    = (shape == CfgTruncated || shape == CfgHugeSize);
    version = AvccVersion;
    if (shape == CfgBadVersion) begin
      version = 8'($urandom);
      if (version == AvccVersion) version = 8'h00;
    end
    rec_q.push_back(version);
    repeat (4) rec_q.push_back(8'($urandom));
    sps = wild ? $urandom_range(0, 31) : $urandom_range(0, 3);
    if (shape == CfgOverlong && sps == 0) sps = 1;
    rec_q.push_back(8'(($urandom_range(0, 7) << 5) | sps));
    if (shape == CfgOverlong) begin
      len16 = 16'($urandom_range(256, 65535));
      rec_q.push_back(len16[15:8]);
      rec_q.push_back(len16[7:0]);
      repeat ($urandom_range(0, 3)) rec_q.push_back(8'($urandom));
    end else begin
      push_entries(sps > 3 ? 3 : sps);
      pps = wild ? $urandom_range(0, 255) : $urandom_range(0, 3);
      rec_q.push_back(8'(pps));
      push_entries(pps > 3 ? 3 : pps);
    end
    body = rec_q.size();
    case (shape)
      CfgShort:     decl = RecordSizeW'($urandom_range(0, AvccMinSize - 1));
      CfgTruncated: decl = RecordSizeW'($urandom_range(AvccMinSize, body - 1));
      CfgHugeSize:  decl = RecordSizeW'($urandom);
      CfgPastEnd: begin
        decl = RecordSizeW'(body);
        repeat ($urandom_range(1, 3)) rec_q.push_back(8'($urandom));
      end
      default:      decl = RecordSizeW'(body);
    endcase
  endtask

  // One random record, sample or configuration, well-formed or broken.
  task automatic send_random_record();
    logic [RecordSizeW-1:0] decl;
    int                     n;
    int                     pick;
    if ($urandom_range(0, 9) < 5) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
      build_sample_record(n);
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        decl = RecordSizeW'(n);
      end else if (pick == 7) begin
        decl = RecordSizeW'($urandom_range(0, n));
      end else if (pick == 8) begin
        decl = RecordSizeW'($urandom);
      end else begin
        decl = RecordSizeW'(n + $urandom_range(1, 8));
      end
      send_record(ModeSample, decl);
    end else begin
      pick = $urandom_range(0, 11);
      build_config_record(pick < 6 ? CfgWellFormed : cfg_shape_e'(pick - 5), decl);
      send_record(ModeConfig, decl);
    end
  endtask

  // Before any record the block is in sample mode with size zero.
  task automatic test_before_first_record();
    in_byte_t it;
    it.first = 1'b0;
    it.func  = 1'b1;
    it.size  = PosMax;
    it.data  = 8'hff;
    send_byte(it);
    it.data  = 8'h00;
    it.size  = '0;
    send_byte(it);
  endtask

  // A header that ends too close to the record end is not converted;
  // a byte beyond the record end passes through.
  task automatic test_sample_header_boundary();
    rec_q = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h5a, 8'hff, 8'h80, 8'h7f, 8'h01, 8'h00};
    send_record(ModeSample, 24'd9);
  endtask

  // One SPS with payload, one empty PPS, then a byte past the record end.
  task automatic test_config_record();
    rec_q = '{8'h01, 8'h64, 8'h00, 8'h1f, 8'hff, 8'he1, 8'h00, 8'h01, 8'h67,
              8'h01, 8'h00, 8'h00, 8'h3c};
    send_record(ModeConfig, 24'd12);
  endtask

  task automatic test_random_records(input int unsigned target);
    int unsigned stop_at;
    stop_at = items_sent + target;
    while (items_sent < stop_at) send_random_record();
  endtask

  // The receiver stalls for a long time while a long record keeps coming.
  task automatic test_output_hold();
    logic [RecordSizeW-1:0] decl;
    hold_cycles = HoldCycles;
    build_sample_record(40);
    send_record(ModeSample, 24'd40);
    build_config_record(CfgWellFormed, decl);
    send_record(ModeConfig, decl);
  endtask

  // The last part of the run goes at full rate on both sides.
  task automatic test_full_rate_tail(input int unsigned target);
    idle_on = 1'b0;
    test_random_records(target);
  endtask

  // Compare each output beat with the oldest expectation.
  always @(posedge clk_i) begin
    out_byte_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual byte %02h last %0b",
                 $time, out_ch.out_byte, out_ch.out_last);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        if (out_ch.out_byte !== want.data) begin
          $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                   $time, want.data, out_ch.out_byte);
          errors++;
        end
        if (out_ch.out_last !== want.last) begin
          $display("%0t: out_last mismatch, expected %0b, actual %0b",
                   $time, want.last, out_ch.out_last);
          errors++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Receiver: random stall bursts, calm stretches and the long hold-off.
  initial begin : receiver
    int burst;
    int calm;
    calm = 0;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        burst       = hold_cycles;
        hold_cycles = 0;
        out_ch.ready <= 1'b0;
        repeat (burst - 1) @(posedge clk_i);
      end else if (idle_on && calm == 0 && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 19);
        out_ch.ready <= 1'b0;
        repeat (burst - 1) @(posedge clk_i);
        if ($urandom_range(0, 3) == 0) calm = $urandom_range(20, 80);
      end else begin
        out_ch.ready <= 1'b1;
        if (calm > 0) calm--;
      end
    end
  end

  initial begin
    in_ch.valid           <= 1'b0;
    in_ch.func            <= 1'b0;
    in_ch.data_byte       <= '0;
    in_ch.first_of_record <= 1'b0;
    in_ch.record_size     <= '0;
    clear_parser();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_before_first_record();
    test_sample_header_boundary();
    test_config_record();
    test_random_records(260);
    test_output_hold();
    test_full_rate_tail(60);

    in_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/lpsc_pkg.sv
rtl/lpsc_in_if.sv
rtl/lpsc_out_if.sv
rtl/length_prefix_to_start_code.sv
test/tb_top.sv
